>>> rtl/bmmh_pkg.sv
// Package with the constants, types and helper functions of the block multiply-mix hash.
package bmmh_pkg;

   // Block and word geometry.
   localparam int BLOCK_BYTES = 7;
   localparam int WORD_COUNT  = 10;
   localparam int COUNT_W     = $clog2(BLOCK_BYTES + 1);
   localparam int IDX_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int PAIR_W      = $clog2(WORD_COUNT);
   localparam int WORD_W      = 32;

   // Digest alphabet geometry.
   localparam int ALPHA_LEN   = 37;
   localparam int REM_W       = $clog2(ALPHA_LEN);

   // Remainder modulo 37: the 32-bit magnitude is folded with 2^18 = -1 (mod 37), and the
   // 19-bit folded value is divided by reciprocal multiplication.
   localparam int FOLD_SHIFT  = 18;
   localparam int FOLD_W      = 19;
   localparam int FOLD_BIAS   = 16391;   // 443 * 37, above any high part of the magnitude
   localparam int RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_37 = 20'd906877;   // ceil(2^25 / 37)
   localparam int RECIP_SHIFT = 25;
   localparam int QUOT_W      = 13;

   // Initial hash words, reloaded after every digest.
   localparam logic [WORD_W-1:0] INIT_WORDS [10] = '{
      32'd67, 32'd7001, 32'd173, 32'd127, 32'd181,
      32'd193, 32'd10037, 32'd27487, 32'd9281, 32'd7583
   };

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_ALIGN,
      ST_LOAD,
      ST_FOLD,
      ST_QUOT,
      ST_REM,
      ST_EMIT
   } state_type;

   // Maps a remainder to its character: a-z, then 0-9, then underscore.
   function automatic logic [7:0] alpha_char(input logic [REM_W-1:0] idx);
      logic [7:0] wide;
      wide = {{(8 - REM_W){1'b0}}, idx};
      if (wide < 8'd26) begin
         return 8'h61 + wide;
      end else if (wide < 8'd36) begin
         return 8'h30 + (wide - 8'd26);
      end else begin
         return 8'h5f;
      end
   endfunction

endpackage

>>> rtl/block_multiply_mix_hash.sv
// Top level of the block multiply-mix hash: byte buffer, shared multiply-add unit and digest.
//
// Usage: message bytes arrive on the req_ stream, one transaction per byte. req_tuser
// flags whether req_tdata carries a byte; req_tlast ends the message (an empty
// transaction with req_tlast set is allowed). After each completed message the block
// sends ten digest characters on the rsp_ stream, rsp_tlast marking the tenth.
// A byte that does not complete a block is only stored in the buffer. A full block, or the
// partial block left at the end of a message, is mixed by one shared 32x8 multiply-add
// unit, one byte per cycle: 18 updates of len bytes each plus one alignment step; a full
// block holds seven bytes. Each digest character takes one load, one modulo-37 fold,
// one reciprocal multiplication, one remainder step and one emit, and the emit waits
// while the receiver stalls. req_tready is high only while the sequencer is idle.
// A stalled receiver holds the current character in the output register and the
// sequencer waits for it; the last character may still wait while the next message
// byte is accepted. Reset is synchronous: it loads the initial words, empties the
// buffer and drops rsp_tvalid.
module block_multiply_mix_hash (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic [0:0] req_tuser,  // [0] carries_byte
   input  logic       req_tlast,  // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] symbol
   output logic       rsp_tlast   // last_symbol
);
   import bmmh_pkg::*;

   // Registers and their next values.
   state_type                state_ff, state_in;
   logic [WORD_W-1:0]        words_ff [WORD_COUNT];
   logic [WORD_W-1:0]        words_in [WORD_COUNT];
   logic [7:0]               buffer_ff [BLOCK_BYTES];
   logic [COUNT_W-1:0]       fill_ff, fill_in;
   logic [COUNT_W-1:0]       len_ff, len_in;
   logic [IDX_W-1:0]         byte_idx_ff, byte_idx_in;
   logic                     phase_ff, phase_in;
   logic [PAIR_W-1:0]        pair_ff, pair_in;
   logic [PAIR_W-1:0]        sym_ff, sym_in;
   logic                     finish_ff, finish_in;
   logic [WORD_W-1:0]        mod_val_ff, mod_val_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic                     req_accept;
   logic                     rsp_load;
   logic [COUNT_W-1:0]       new_count;
   logic                     last_byte;
   logic [WORD_W-1:0]        self_word;
   logic [WORD_W-1:0]        other_word;
   logic signed [WORD_W+7:0] prod_full;
   logic [WORD_W-1:0]        mix_result;
   logic [WORD_W-1:0]        magnitude;
   logic [FOLD_W-1:0]        fold_val;
   logic [FOLD_W+RECIP_W-1:0] quot_prod;
   logic [FOLD_W-1:0]        rem_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Byte count after the current transaction.
   assign new_count = fill_ff + COUNT_W'(req_tuser[0]);
   assign last_byte = (COUNT_W'(byte_idx_ff) == len_ff - COUNT_W'(1));

   // Shared multiply-add unit: self + (other >>> 3) + self * byte, 32-bit wrap.
   assign self_word  = phase_ff ? words_ff[1] : words_ff[0];
   assign other_word = phase_ff ? words_ff[0] : words_ff[1];
   assign prod_full  = $signed(self_word) * $signed(buffer_ff[byte_idx_ff]);
   assign mix_result = self_word + {{3{other_word[WORD_W-1]}}, other_word[WORD_W-1:3]}
                       + prod_full[WORD_W-1:0];

   // Magnitude of the front word; the most negative value reads as 2^31 unsigned.
   assign magnitude = words_ff[0][WORD_W-1] ? (WORD_W'(0) - words_ff[0]) : words_ff[0];

   // Fold: the high bits count negatively since 2^18 is -1 modulo 37; the bias is a
   // multiple of 37 that keeps the folded value positive.
   assign fold_val = FOLD_W'(mod_val_ff[FOLD_SHIFT-1:0]) + FOLD_W'(FOLD_BIAS)
                     - FOLD_W'(mod_val_ff[WORD_W-1:FOLD_SHIFT]);

   // Quotient by 37 through the reciprocal, exact over the folded range.
   assign quot_prod = (FOLD_W + RECIP_W)'(mod_val_ff[FOLD_W-1:0])
                      * (FOLD_W + RECIP_W)'(RECIP_37);

   // Remainder from the folded value and its quotient.
   assign rem_wide = mod_val_ff[FOLD_W-1:0] - FOLD_W'(quot_ff) * FOLD_W'(ALPHA_LEN);

   // Next state and datapath values.
   always_comb begin
      state_in     = state_ff;
      words_in     = words_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      byte_idx_in  = byte_idx_ff;
      phase_in     = phase_ff;
      pair_in      = pair_ff;
      sym_in       = sym_ff;
      finish_in    = finish_ff;
      mod_val_in   = mod_val_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((new_count == COUNT_W'(BLOCK_BYTES)) ||
                   (req_tlast && (new_count != COUNT_W'(0)))) begin
                  // Mix the full block or the partial block left at the end.
                  len_in      = new_count;
                  fill_in     = '0;
                  finish_in   = req_tlast;
                  byte_idx_in = '0;
                  phase_in    = 1'b0;
                  pair_in     = '0;
                  state_in    = ST_MIX;
               end else if (req_tlast) begin
                  // Empty message: go straight to the digest.
                  sym_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  fill_in = new_count;
               end
            end
         end

         ST_MIX: begin
            if (!last_byte) begin
               words_in[PAIR_W'(phase_ff)] = mix_result;
               byte_idx_in                 = byte_idx_ff + IDX_W'(1);
            end else if (!phase_ff) begin
               words_in[0] = mix_result;
               byte_idx_in = '0;
               phase_in    = 1'b1;
            end else begin
               // Second update of the pair done: rotate so the next pair sits in front.
               for (int j = 0; j < WORD_COUNT - 1; j++) begin
                  words_in[j] = words_ff[j + 1];
               end
               words_in[0]              = mix_result;
               words_in[WORD_COUNT - 1] = words_ff[0];
               byte_idx_in              = '0;
               phase_in                 = 1'b0;
               if (pair_ff == PAIR_W'(WORD_COUNT - 2)) begin
                  pair_in  = '0;
                  state_in = ST_ALIGN;
               end else begin
                  pair_in = pair_ff + PAIR_W'(1);
               end
            end
         end

         ST_ALIGN: begin
            // One more rotation brings word zero back to the front.
            for (int j = 0; j < WORD_COUNT - 1; j++) begin
               words_in[j] = words_ff[j + 1];
            end
            words_in[WORD_COUNT - 1] = words_ff[0];
            finish_in = 1'b0;
            sym_in    = '0;
            state_in  = finish_ff ? ST_LOAD : ST_IDLE;
         end

         ST_LOAD: begin
            mod_val_in = magnitude;
            state_in   = ST_FOLD;
         end

         ST_FOLD: begin
            mod_val_in = WORD_W'(fold_val);
            state_in   = ST_QUOT;
         end

         ST_QUOT: begin
            quot_in  = quot_prod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_REM;
         end

         ST_REM: begin
            rem_in   = rem_wide[REM_W-1:0];
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = alpha_char(rem_ff);
               rsp_last_in  = (sym_ff == PAIR_W'(WORD_COUNT - 1));
               if (sym_ff == PAIR_W'(WORD_COUNT - 1)) begin
                  // Digest complete: reload the initial words.
                  for (int j = 0; j < WORD_COUNT; j++) begin
                     words_in[j] = INIT_WORDS[j];
                  end
                  sym_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  for (int j = 0; j < WORD_COUNT - 1; j++) begin
                     words_in[j] = words_ff[j + 1];
                  end
                  words_in[WORD_COUNT - 1] = words_ff[0];
                  sym_in   = sym_ff + PAIR_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and hash-word registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WORD_COUNT; j++) begin
            words_ff[j] <= INIT_WORDS[j];
         end
         fill_ff      <= '0;
         len_ff       <= '0;
         byte_idx_ff  <= '0;
         phase_ff     <= 1'b0;
         pair_ff      <= '0;
         sym_ff       <= '0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         words_ff     <= words_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         byte_idx_ff  <= byte_idx_in;
         phase_ff     <= phase_in;
         pair_ff      <= pair_in;
         sym_ff       <= sym_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: modulo unit, output register and block buffer.
   always_ff @(posedge clock) begin
      mod_val_ff  <= mod_val_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_accept && req_tuser[0]) begin
         buffer_ff[fill_ff[IDX_W-1:0]] <= req_tdata;
      end
   end

   // The fill count never reaches a full block between transactions.
   a_fill_below_block: assert property (@(posedge clock) disable iff (reset)
      fill_ff < COUNT_W'(BLOCK_BYTES))
      else $error("fill count reached a full block");

   // The byte index of the shared unit stays inside the block being mixed.
   a_byte_idx_in_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> (COUNT_W'(byte_idx_ff) < len_ff))
      else $error("byte index beyond block length");

   // The remainder handed to the output is reduced modulo 37.
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff < REM_W'(ALPHA_LEN)))
      else $error("remainder not reduced");

   // An empty message goes straight to the digest without a mix.
   a_empty_message: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast && !req_tuser[0] && fill_ff == COUNT_W'(0))
      |=> (state_ff == ST_LOAD))
      else $error("empty message did not start the digest");

   // After the last character the initial words are back in place.
   a_reload_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && sym_ff == PAIR_W'(WORD_COUNT - 1))
      |=> (words_ff[0] == INIT_WORDS[0] && rsp_tlast && state_ff == ST_IDLE))
      else $error("initial words not reloaded after the digest");

endmodule
